// ===== design/mtg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and helper functions of the Mersenne Twister
// generator unit.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int KEY_DEPTH    = 624;

  localparam int SW_AW     = $clog2(STATE_WORDS);
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);
  localparam int STEP_MAX  = (KEY_DEPTH > STATE_WORDS) ? KEY_DEPTH : STATE_WORDS;
  localparam int STEP_CW   = $clog2(STEP_MAX + 1);
  localparam int FAR_BACK  = STATE_WORDS - TWIST_OFFSET;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] KEY_MULT     = 32'd1664525;
  localparam logic [31:0] FINAL_MULT   = 32'd1566083941;
  localparam logic [31:0] KEY_BASE     = 32'd19650218;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LOW_BITS     = 32'h7fffffff;

  typedef enum logic [2:0] {
    OP_SEED    = 3'd0,
    OP_PUSH    = 3'd1,
    OP_KEYSEED = 3'd2,
    OP_DRAW    = 3'd3,
    OP_DRAW53  = 3'd4,
    OP_WRITE   = 3'd5,
    OP_READ    = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] data_word;
    logic [9:0]  slot;
    logic [5:0]  bit_count;
  } cmd_t;

  typedef struct packed {
    logic [52:0] value;
    logic        status;
  } rsp_t;

  // One twist step: upper bit of one word, lower bits of the next.
  function automatic logic [31:0] mix_pair(input logic [31:0] upper,
                                           input logic [31:0] lower,
                                           input logic [31:0] far_word);
    logic [31:0] y;
    begin
      y = (upper & HIGH_BIT) | (lower & LOW_BITS);
      mix_pair = far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    end
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    begin
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      temper = y ^ (y >> 18);
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/mtg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/mersenne_twister_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit
// MT19937 generator built around a 624-word state memory and a key memory,
// driven by one sequencer that reads, modifies and writes back the state.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | opcode, data_word, slot, bits
//  rsp     | out       | rsp_valid / rsp_stall  | value, status
//
// A transfer on cmd is taken only while the sequencer is idle; every command
// returns exactly one transfer on rsp. A draw reads each word it takes from
// the state memory, and when the position has reached 624 it first
// regenerates the whole store through the single read port of the state
// memory. Seeding from one word passes each entry through the registered
// multiplier; seeding from the key runs that pass, then max(624, key count)
// key steps and 623 final steps. After reset the state memory is cleared in
// one pass over its 624 words, during which cmd_stall is held high. The
// result sits in an output register, so a stall on rsp only holds the
// sequencer once it has the next result ready.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit
  import mtg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIN, S_RDWAIT, S_DCHK, S_DRD,
    S_TLOAD, S_TC0, S_TF, S_TW, S_SEED0, S_MA, S_MB, S_WRAP, S_LAST
  } state_t;

  typedef enum logic [1:0] {M_LIN, M_KEY, M_FIN} mode_t;

  localparam logic [SW_AW-1:0] LAST_IDX = SW_AW'(STATE_WORDS - 1);

  state_t              state;
  mode_t               mode;
  logic [SW_AW-1:0]    idx;
  logic [KEY_AW-1:0]   kidx;
  logic [STEP_CW-1:0]  steps;
  logic [SW_AW-1:0]    pos;
  logic [KEY_CW-1:0]   key_count;
  logic                fin_done;
  logic                half;

  logic [2:0]          op_q;
  logic [31:0]         data_q;
  logic [5:0]          bits_q;

  logic [31:0]         cur;
  logic [31:0]         nxt;
  logic [31:0]         prev;
  logic [31:0]         mul;
  logic [26:0]         first_part;
  logic [52:0]         res_value;
  logic                res_status;

  // Memory ports.
  logic                t_we;
  logic [SW_AW-1:0]    t_waddr;
  logic [31:0]         t_wdata;
  logic [SW_AW-1:0]    t_raddr;
  logic [31:0]         t_rdata;
  logic                k_we;
  logic [KEY_AW-1:0]   k_waddr;
  logic [KEY_AW-1:0]   k_raddr;
  logic [31:0]         k_rdata;

  logic [31:0]         mix_in;
  logic [31:0]         mul_k;
  logic [31:0]         mul_next;
  logic [31:0]         step_val;
  logic [31:0]         drawn;
  logic [5:0]          bits_eff;
  logic [4:0]          shift;
  logic [SW_AW-1:0]    idx_inc;
  logic [SW_AW-1:0]    idx_inc2;
  logic [SW_AW-1:0]    idx_far;
  logic [STEP_CW-1:0]  steps_init;
  logic                accept;

  mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_twist_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (cmd.data_word),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);

  // Index arithmetic of the twist: neighbour and far word, both wrapping.
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + SW_AW'(1);
  assign idx_inc2 = (idx_inc == LAST_IDX) ? '0 : idx_inc + SW_AW'(1);
  assign idx_far  = (idx < SW_AW'(FAR_BACK)) ? idx + SW_AW'(TWIST_OFFSET)
                                             : idx - SW_AW'(FAR_BACK);

  assign steps_init = (STEP_CW'(key_count) > STEP_CW'(STATE_WORDS)) ?
                      STEP_CW'(key_count) : STEP_CW'(STATE_WORDS);

  // Shared multiplier of the seeding passes; its product is registered.
  always_comb begin
    mix_in = prev ^ (prev >> 30);
    unique case (mode)
      M_LIN:   mul_k = INIT_MULT;
      M_KEY:   mul_k = KEY_MULT;
      M_FIN:   mul_k = FINAL_MULT;
      default: mul_k = INIT_MULT;
    endcase
    mul_next = mix_in * mul_k;
    unique case (mode)
      M_LIN:   step_val = mul + 32'(idx);
      M_KEY:   step_val = (t_rdata ^ mul) + k_rdata + 32'(kidx);
      M_FIN:   step_val = (t_rdata ^ mul) - 32'(idx);
      default: step_val = mul;
    endcase
  end

  // Draw path: temper the word just read and keep the requested top bits.
  always_comb begin
    drawn = temper(t_rdata);
    if (bits_q == 6'd0) begin
      bits_eff = 6'd1;
    end else if (bits_q > 6'd32) begin
      bits_eff = 6'd32;
    end else begin
      bits_eff = bits_q;
    end
    shift = 5'(6'd32 - bits_eff);
  end

  // Memory port control.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx;
    t_wdata = 32'd0;
    t_raddr = idx;
    k_we    = 1'b0;
    k_waddr = key_count[KEY_AW-1:0];
    k_raddr = kidx;
    unique case (state)
      S_CLEAR: begin
        t_we = 1'b1;
      end
      S_IDLE: begin
        t_waddr = cmd.slot;
        t_wdata = cmd.data_word;
        t_raddr = cmd.slot;
        if (accept && cmd.opcode == OP_PUSH && key_count < KEY_CW'(KEY_DEPTH)) begin
          k_we = 1'b1;
        end
        if (accept && cmd.opcode == OP_WRITE && cmd.slot < 10'(STATE_WORDS)) begin
          t_we = 1'b1;
        end
      end
      S_DCHK:  t_raddr = pos;
      S_TLOAD: t_raddr = '0;
      S_TC0:   t_raddr = idx_inc;
      S_TF:    t_raddr = idx_far;
      S_TW: begin
        t_we    = 1'b1;
        t_wdata = mix_pair(cur, nxt, t_rdata);
        t_raddr = idx_inc2;
      end
      S_SEED0: begin
        t_we    = 1'b1;
        t_waddr = '0;
        t_wdata = (op_q == OP_SEED) ? data_q : KEY_BASE;
      end
      S_MB: begin
        t_we    = 1'b1;
        t_wdata = step_val;
      end
      S_WRAP: begin
        t_we    = 1'b1;
        t_waddr = '0;
        t_wdata = prev;
      end
      S_LAST: begin
        t_we    = 1'b1;
        t_waddr = '0;
        t_wdata = HIGH_BIT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      pos       <= SW_AW'(STATE_WORDS);
      key_count <= '0;
      rsp_valid <= 1'b0;
      mode      <= M_LIN;
      fin_done  <= 1'b0;
      half      <= 1'b0;
    end else begin
      // In S_FIN the output register is loaded whenever it would drain.
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx_inc;
          if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op_q   <= cmd.opcode;
            data_q <= cmd.data_word;
            bits_q <= cmd.bit_count;
            half   <= 1'b0;
            unique case (cmd.opcode)
              OP_SEED: begin
                res_value  <= '0;
                res_status <= 1'b0;
                state      <= S_SEED0;
              end
              OP_PUSH: begin
                res_value <= '0;
                state     <= S_FIN;
                if (key_count >= KEY_CW'(KEY_DEPTH)) begin
                  res_status <= 1'b1;
                end else begin
                  res_status <= 1'b0;
                  key_count  <= key_count + KEY_CW'(1);
                end
              end
              OP_KEYSEED: begin
                res_value <= '0;
                if (key_count == '0) begin
                  res_status <= 1'b1;
                  state      <= S_FIN;
                end else begin
                  res_status <= 1'b0;
                  state      <= S_SEED0;
                end
              end
              OP_DRAW, OP_DRAW53: begin
                res_value  <= '0;
                res_status <= 1'b0;
                state      <= S_DCHK;
              end
              OP_WRITE: begin
                res_value <= '0;
                state     <= S_FIN;
                if (cmd.slot < 10'(STATE_WORDS)) begin
                  // The memory write happens in this cycle.
                  res_status <= 1'b0;
                end else if (cmd.slot == 10'(STATE_WORDS) &&
                             cmd.data_word <= 32'(STATE_WORDS)) begin
                  pos        <= cmd.data_word[SW_AW-1:0];
                  res_status <= 1'b0;
                end else begin
                  res_status <= 1'b1;
                end
              end
              OP_READ: begin
                if (cmd.slot < 10'(STATE_WORDS)) begin
                  res_value  <= '0;
                  res_status <= 1'b0;
                  state      <= S_RDWAIT;
                end else if (cmd.slot == 10'(STATE_WORDS)) begin
                  res_value  <= 53'(pos);
                  res_status <= 1'b0;
                  state      <= S_FIN;
                end else begin
                  res_value  <= '0;
                  res_status <= 1'b1;
                  state      <= S_FIN;
                end
              end
              default: begin
                res_value  <= '0;
                res_status <= 1'b1;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_value <= 53'(t_rdata);
          state     <= S_FIN;
        end
        S_DCHK: begin
          state <= (pos == SW_AW'(STATE_WORDS)) ? S_TLOAD : S_DRD;
        end
        S_DRD: begin
          pos <= pos + SW_AW'(1);
          if (op_q == OP_DRAW53) begin
            if (!half) begin
              first_part <= drawn[31:5];
              half       <= 1'b1;
              state      <= S_DCHK;
            end else begin
              res_value <= {first_part, drawn[31:6]};
              state     <= S_FIN;
            end
          end else begin
            res_value <= 53'(drawn >> shift);
            state     <= S_FIN;
          end
        end
        S_TLOAD: begin
          idx   <= '0;
          state <= S_TC0;
        end
        S_TC0: begin
          cur   <= t_rdata;
          state <= S_TF;
        end
        S_TF: begin
          nxt   <= t_rdata;
          state <= S_TW;
        end
        S_TW: begin
          cur <= nxt;
          if (idx == LAST_IDX) begin
            pos   <= '0;
            state <= S_DCHK;
          end else begin
            idx   <= idx_inc;
            state <= S_TF;
          end
        end
        S_SEED0: begin
          prev     <= (op_q == OP_SEED) ? data_q : KEY_BASE;
          idx      <= SW_AW'(1);
          mode     <= M_LIN;
          fin_done <= 1'b0;
          state    <= S_MA;
        end
        S_MA: begin
          mul   <= mul_next;
          state <= S_MB;
        end
        S_MB: begin
          unique case (mode)
            M_LIN: begin
              if (idx == LAST_IDX) begin
                if (op_q == OP_KEYSEED) begin
                  // The key pass starts from word 0 of the fresh seeding.
                  mode  <= M_KEY;
                  prev  <= KEY_BASE;
                  idx   <= SW_AW'(1);
                  kidx  <= '0;
                  steps <= steps_init;
                  state <= S_MA;
                end else begin
                  prev  <= step_val;
                  pos   <= SW_AW'(STATE_WORDS);
                  state <= S_FIN;
                end
              end else begin
                prev  <= step_val;
                idx   <= idx_inc;
                state <= S_MA;
              end
            end
            M_KEY, M_FIN: begin
              prev <= step_val;
              if (mode == M_KEY) begin
                kidx <= (KEY_CW'(kidx) + KEY_CW'(1) >= key_count) ?
                        '0 : kidx + KEY_AW'(1);
              end
              if (mode == M_KEY && steps == STEP_CW'(1)) begin
                mode  <= M_FIN;
                steps <= STEP_CW'(STATE_WORDS - 1);
              end else begin
                steps <= steps - STEP_CW'(1);
              end
              fin_done <= (mode == M_FIN) && (steps == STEP_CW'(1));
              if (idx == LAST_IDX) begin
                idx   <= SW_AW'(1);
                state <= S_WRAP;
              end else begin
                idx   <= idx_inc;
                state <= ((mode == M_FIN) && (steps == STEP_CW'(1))) ? S_LAST : S_MA;
              end
            end
            default: begin
              prev  <= step_val;
              state <= S_MA;
            end
          endcase
        end
        S_WRAP: begin
          state <= fin_done ? S_LAST : S_MA;
        end
        S_LAST: begin
          key_count <= '0;
          pos       <= SW_AW'(STATE_WORDS);
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.value  <= res_value;
            rsp.status <= res_status;
            rsp_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Mersenne Twister generator unit: a directed
// table, a pass that fills the key store, then weighted random commands,
// scored against a behavioural bench copy or, for typed rows, fixed results.
// ----------------------------------------------------------------------------
module tb
  import mtg_pkg::*;
();

  // Opcode with no operation behind it; the unit must reject it.
  localparam logic [2:0] OP_BAD = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  mersenne_twister_generator_unit dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Behavioural copy of the generator state.
  logic [31:0] gen_words [STATE_WORDS];
  logic [31:0] gen_keys [KEY_DEPTH];
  int unsigned gen_pos;
  int unsigned gen_key_cnt;

  rsp_t expected_rsps [$];
  int errors = 0;
  int n_draws = 0, n_seeds = 0, n_rejects = 0, n_regens = 0;
  bit quiet = 1'b0;   // when set, neither side inserts gaps

  task automatic report(string what, rsp_t got, rsp_t want);
    $display("%0t mismatch %s: got value %h status %0d, want value %h status %0d",
             $time, what, got.value, got.status, want.value, want.status);
    errors++;
  endtask

  function automatic void regenerate_words();
    logic [31:0] y;
    for (int i = 0; i < STATE_WORDS; i++) begin
      y = (gen_words[i] & HIGH_BIT) |
          (gen_words[(i + 1) % STATE_WORDS] & LOW_BITS);
      gen_words[i] = gen_words[(i + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1) ^
                     (y[0] ? TWIST_MATRIX : 32'd0);
    end
    gen_pos = 0;
    n_regens++;
  endfunction

  function automatic logic [31:0] next_tempered();
    logic [31:0] y;
    if (gen_pos >= STATE_WORDS) regenerate_words();
    y = gen_words[gen_pos];
    gen_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  function automatic void seed_from_word(logic [31:0] s);
    logic [31:0] p;
    gen_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = gen_words[i - 1];
      gen_words[i] = INIT_MULT * (p ^ (p >> 30)) + i;
    end
    gen_pos = STATE_WORDS;
  endfunction

  function automatic void seed_from_keys(int unsigned len);
    logic [31:0] p;
    int i, j, k;
    seed_from_word(KEY_BASE);
    i = 1;
    j = 0;
    for (k = (len > STATE_WORDS) ? len : STATE_WORDS; k > 0; k--) begin
      p = gen_words[i - 1];
      gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 30)) * KEY_MULT)) + gen_keys[j] + j;
      i++;
      j++;
      if (i >= STATE_WORDS) begin
        gen_words[0] = gen_words[STATE_WORDS - 1];
        i = 1;
      end
      if (j >= len) j = 0;
    end
    for (k = STATE_WORDS - 1; k > 0; k--) begin
      p = gen_words[i - 1];
      gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 30)) * FINAL_MULT)) - i;
      i++;
      if (i >= STATE_WORDS) begin
        gen_words[0] = gen_words[STATE_WORDS - 1];
        i = 1;
      end
    end
    gen_words[0] = HIGH_BIT;
  endfunction

  // Applies one command to the bench copy and returns the result it must give.
  function automatic rsp_t predict_generator(cmd_t c);
    rsp_t r;
    int unsigned nb;
    logic [31:0] a, b;
    r = '0;
    case (c.opcode)
      OP_SEED: begin
        seed_from_word(c.data_word);
        n_seeds++;
      end
      OP_PUSH: begin
        if (gen_key_cnt >= KEY_DEPTH) r.status = 1'b1;
        else begin
          gen_keys[gen_key_cnt] = c.data_word;
          gen_key_cnt++;
        end
      end
      OP_KEYSEED: begin
        if (gen_key_cnt == 0) r.status = 1'b1;
        else begin
          seed_from_keys(gen_key_cnt);
          gen_key_cnt = 0;
          n_seeds++;
        end
      end
      OP_DRAW: begin
        nb = 32'(c.bit_count);
        if (nb == 0) nb = 1;
        if (nb > 32) nb = 32;
        r.value = 53'(next_tempered() >> (32 - nb));
        n_draws++;
      end
      OP_DRAW53: begin
        a = next_tempered() >> 5;
        b = next_tempered() >> 6;
        r.value = {a[26:0], b[25:0]};
        n_draws++;
      end
      OP_WRITE: begin
        if (c.slot < STATE_WORDS) gen_words[c.slot] = c.data_word;
        else if (c.slot == STATE_WORDS && c.data_word <= STATE_WORDS) gen_pos = c.data_word;
        else r.status = 1'b1;
      end
      OP_READ: begin
        if (c.slot < STATE_WORDS) r.value = 53'(gen_words[c.slot]);
        else if (c.slot == STATE_WORDS) r.value = 53'(gen_pos);
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    if (r.status) n_rejects++;
    return r;
  endfunction

  // Gap length: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one command and waits for its transfer. Valid stays high into
  // the next command unless a gap is inserted, so it is never dropped and
  // raised within the same edge.
  task automatic send_command(cmd_t c, bit typed = 1'b0, rsp_t typed_rsp = '0);
    int gap;
    rsp_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      cmd <= $bits(cmd_t)'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    pred = predict_generator(c);
    expected_rsps.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Result side back-pressure, with the same gap profile.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      rsp_stall <= 1'b0;
    end
  end

  // Scoreboard: every result transfer is checked against the oldest expectation.
  rsp_t want;
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t unexpected result transfer: value %h status %0d",
                 $time, rsp.value, rsp.status);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.value !== want.value) report("value", rsp, want);
        else if (rsp.status !== want.status) report("status", rsp, want);
      end
    end
  end

  // Directed table; the typed flag marks rows whose result is obvious.
  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t r;
  } table_row_t;

  localparam rsp_t REJECTED = '{value: '0, status: 1'b1};
  localparam rsp_t DONE     = '{value: '0, status: 1'b0};

  table_row_t directed [] = '{
    '{'{OP_READ,    32'h0,        10'd0,    6'd0},  1, '{53'd0,   1'b0}},
    '{'{OP_READ,    32'h0,        10'd624,  6'd0},  1, '{53'd624, 1'b0}},
    '{'{OP_BAD,     32'hffffffff, 10'h3ff,  6'h3f}, 1, REJECTED},
    '{'{OP_READ,    32'h0,        10'd1023, 6'd0},  1, REJECTED},
    '{'{OP_WRITE,   32'h0,        10'd625,  6'd0},  1, REJECTED},
    '{'{OP_KEYSEED, 32'h0,        10'd0,    6'd0},  1, REJECTED},
    '{'{OP_WRITE,   32'd625,      10'd624,  6'd0},  1, REJECTED},
    '{'{OP_DRAW,    32'h0,        10'd0,    6'd32}, 1, DONE},
    '{'{OP_WRITE,   32'hffffffff, 10'd623,  6'd0},  1, DONE},
    '{'{OP_READ,    32'h0,        10'd623,  6'd0},  1, '{53'hffffffff, 1'b0}},
    '{'{OP_SEED,    32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_DRAW,    32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_DRAW,    32'h0,        10'd0,    6'd1},  0, DONE},
    '{'{OP_DRAW,    32'h0,        10'd0,    6'd63}, 0, DONE},
    '{'{OP_DRAW53,  32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_SEED,    32'hffffffff, 10'd0,    6'd0},  0, DONE},
    '{'{OP_WRITE,   32'd623,      10'd624,  6'd0},  0, DONE},
    '{'{OP_DRAW53,  32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_READ,    32'h0,        10'd624,  6'd0},  0, DONE},
    '{'{OP_PUSH,    32'hffffffff, 10'd0,    6'd0},  0, DONE},
    '{'{OP_PUSH,    32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_KEYSEED, 32'h0,        10'd0,    6'd0},  0, DONE},
    '{'{OP_READ,    32'h0,        10'd1,    6'd0},  0, DONE},
    '{'{OP_DRAW,    32'h0,        10'd0,    6'd16}, 0, DONE}
  };

  function automatic cmd_t random_command();
    cmd_t c;
    int r;
    c.data_word = $urandom;
    c.bit_count = 6'($urandom_range(0, 63));
    c.slot = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 624))
                                         : 10'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 36) c.opcode = OP_DRAW;
    else if (r < 56) c.opcode = OP_DRAW53;
    else if (r < 68) c.opcode = OP_READ;
    else if (r < 79) begin
      c.opcode = OP_WRITE;
      // Mostly legal positions so that draws resume from varied points.
      if ($urandom_range(0, 2) == 0) begin
        c.slot = 10'(STATE_WORDS);
        c.data_word = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 624);
      end
    end
    else if (r < 92) c.opcode = OP_PUSH;
    else if (r < 95) c.opcode = OP_KEYSEED;
    else if (r < 98) c.opcode = OP_SEED;
    else c.opcode = OP_BAD;
    return c;
  endfunction

  initial begin
    cmd_t c;
    for (int i = 0; i < STATE_WORDS; i++) gen_words[i] = '0;
    for (int i = 0; i < KEY_DEPTH; i++) gen_keys[i] = '0;
    gen_pos = STATE_WORDS;
    gen_key_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_command(directed[i].c, directed[i].typed, directed[i].r);
    // Hold back until the directed results are all in.
    wait_for_results();

    // Fill the key store to the brim, push once more, then seed from it.
    while (gen_key_cnt < KEY_DEPTH) begin
      c = random_command();
      c.opcode = OP_PUSH;
      send_command(c);
    end
    c.opcode = OP_PUSH;
    send_command(c, 1'b1, REJECTED);
    c.opcode = OP_KEYSEED;
    send_command(c);
    wait_for_results();

    for (int n = 0; n < 300; n++) begin
      if (n % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_command(random_command());
    end
    quiet = 1'b0;
    wait_for_results();
    repeat (40) @(posedge clk);

    $display("covered %0d draws, %0d seeds, %0d regenerations, %0d rejected commands",
             n_draws, n_seeds, n_regens, n_rejects);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_rsps.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
